// ===== rtl/nea_pkg.sv =====
// Shared types, codes and microprogram for the epsilon-NFA acceptor.
// No dependencies; used by nea_seq and nfa_epsilon_acceptor_top.
package nea_pkg;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_WR_TRANS = 2'd0;
  localparam cmd_t CMD_WR_EPS   = 2'd1;
  localparam cmd_t CMD_SYMBOL   = 2'd2;
  localparam cmd_t CMD_EMPTY    = 2'd3;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_START_STATE = 2'd0;
  localparam cfg_idx_t CFG_ACCEPT_MASK = 2'd1;
  localparam cfg_idx_t CFG_STAY_SYMBOL = 2'd2;

  localparam logic [4:0] STAY_NONE = 5'd16;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_CLEAR      = 4'd1;
  localparam op_t OP_ACCEPT     = 4'd2;
  localparam op_t OP_LOAD_START = 4'd3;
  localparam op_t OP_PASS_INIT  = 4'd4;
  localparam op_t OP_CLOSE      = 4'd5;
  localparam op_t OP_SET_STR    = 4'd6;
  localparam op_t OP_TRANS_INIT = 4'd7;
  localparam op_t OP_TRANS      = 4'd8;
  localparam op_t OP_MOVE       = 4'd9;
  localparam op_t OP_REPORT     = 4'd10;
  localparam op_t OP_WR_TRANS   = 4'd11;
  localparam op_t OP_WR_EPS     = 4'd12;

  // jump conditions
  typedef logic [3:0] cond_t;
  localparam cond_t C_NEVER      = 4'd0;
  localparam cond_t C_ALWAYS     = 4'd1;
  localparam cond_t C_NO_ITEM    = 4'd2;
  localparam cond_t C_CMD_WTR    = 4'd3;
  localparam cond_t C_CMD_WEP    = 4'd4;
  localparam cond_t C_SKIP_START = 4'd5;
  localparam cond_t C_MORE       = 4'd6;
  localparam cond_t C_CHG        = 4'd7;
  localparam cond_t C_CMD_EMPTY  = 4'd8;
  localparam cond_t C_NOT_LAST   = 4'd9;
  localparam cond_t C_OUT_BUSY   = 4'd10;
  localparam cond_t C_CLR_MORE   = 4'd11;

  typedef logic [4:0] upc_t;
  localparam upc_t U_CLR      = 5'd0;
  localparam upc_t U_IDLE     = 5'd1;
  localparam upc_t U_DEC_WTR  = 5'd2;
  localparam upc_t U_DEC_WEP  = 5'd3;
  localparam upc_t U_DEC_STR  = 5'd4;
  localparam upc_t U_ST       = 5'd5;
  localparam upc_t U_ST_PASS  = 5'd6;
  localparam upc_t U_ST_SCAN  = 5'd7;
  localparam upc_t U_ST_CHK   = 5'd8;
  localparam upc_t U_ST_EMPTY = 5'd9;
  localparam upc_t U_SET_STR  = 5'd10;
  localparam upc_t U_TR       = 5'd11;
  localparam upc_t U_TR_SCAN  = 5'd12;
  localparam upc_t U_MOVE     = 5'd13;
  localparam upc_t U_CL_PASS  = 5'd14;
  localparam upc_t U_CL_SCAN  = 5'd15;
  localparam upc_t U_CL_CHK   = 5'd16;
  localparam upc_t U_LAST     = 5'd17;
  localparam upc_t U_REP      = 5'd18;
  localparam upc_t U_REP_DONE = 5'd19;
  localparam upc_t U_WTR      = 5'd20;
  localparam upc_t U_WEP      = 5'd21;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } uword_t;

  // sequencer -> datapath
  typedef struct packed {
    op_t  op;
    logic idle;
  } ctl_t;

  // datapath -> sequencer
  typedef struct packed {
    logic item;
    cmd_t cmd;
    logic in_str;
    logic more;
    logic chg;
    logic last;
    logic out_busy;
    logic clr_more;
  } status_t;

  // control store: fall through to upc+1 unless the condition holds
  function automatic uword_t ucode(upc_t upc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: U_IDLE};
    unique case (upc)
      U_CLR:      w = '{op: OP_CLEAR,      cond: C_CLR_MORE,   target: U_CLR};
      U_IDLE:     w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,    target: U_IDLE};
      U_DEC_WTR:  w = '{op: OP_NOP,        cond: C_CMD_WTR,    target: U_WTR};
      U_DEC_WEP:  w = '{op: OP_NOP,        cond: C_CMD_WEP,    target: U_WEP};
      U_DEC_STR:  w = '{op: OP_NOP,        cond: C_SKIP_START, target: U_TR};
      U_ST:       w = '{op: OP_LOAD_START, cond: C_NEVER,      target: U_IDLE};
      U_ST_PASS:  w = '{op: OP_PASS_INIT,  cond: C_NEVER,      target: U_IDLE};
      U_ST_SCAN:  w = '{op: OP_CLOSE,      cond: C_MORE,       target: U_ST_SCAN};
      U_ST_CHK:   w = '{op: OP_NOP,        cond: C_CHG,        target: U_ST_PASS};
      U_ST_EMPTY: w = '{op: OP_NOP,        cond: C_CMD_EMPTY,  target: U_REP};
      U_SET_STR:  w = '{op: OP_SET_STR,    cond: C_NEVER,      target: U_IDLE};
      U_TR:       w = '{op: OP_TRANS_INIT, cond: C_NEVER,      target: U_IDLE};
      U_TR_SCAN:  w = '{op: OP_TRANS,      cond: C_MORE,       target: U_TR_SCAN};
      U_MOVE:     w = '{op: OP_MOVE,       cond: C_NEVER,      target: U_IDLE};
      U_CL_PASS:  w = '{op: OP_PASS_INIT,  cond: C_NEVER,      target: U_IDLE};
      U_CL_SCAN:  w = '{op: OP_CLOSE,      cond: C_MORE,       target: U_CL_SCAN};
      U_CL_CHK:   w = '{op: OP_NOP,        cond: C_CHG,        target: U_CL_PASS};
      U_LAST:     w = '{op: OP_NOP,        cond: C_NOT_LAST,   target: U_IDLE};
      U_REP:      w = '{op: OP_REPORT,     cond: C_OUT_BUSY,   target: U_REP};
      U_REP_DONE: w = '{op: OP_NOP,        cond: C_ALWAYS,     target: U_IDLE};
      U_WTR:      w = '{op: OP_WR_TRANS,   cond: C_ALWAYS,     target: U_IDLE};
      U_WEP:      w = '{op: OP_WR_EPS,     cond: C_ALWAYS,     target: U_IDLE};
      default:    w = '{op: OP_NOP,        cond: C_ALWAYS,     target: U_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/nea_seq.sv =====
// Microprogram sequencer: step counter, control store lookup, conditional jumps.
// Depends on nea_pkg.
module nea_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  nea_pkg::status_t  st,
  output nea_pkg::ctl_t     ctl
);

  nea_pkg::upc_t   upc_r;
  nea_pkg::upc_t   upc_nxt;
  nea_pkg::uword_t word;
  logic            take;

  always_comb begin
    word = nea_pkg::ucode(upc_r);
    unique case (word.cond)
      nea_pkg::C_NEVER:      take = 1'b0;
      nea_pkg::C_ALWAYS:     take = 1'b1;
      nea_pkg::C_NO_ITEM:    take = !st.item;
      nea_pkg::C_CMD_WTR:    take = (st.cmd == nea_pkg::CMD_WR_TRANS);
      nea_pkg::C_CMD_WEP:    take = (st.cmd == nea_pkg::CMD_WR_EPS);
      nea_pkg::C_SKIP_START: take = st.in_str && (st.cmd == nea_pkg::CMD_SYMBOL);
      nea_pkg::C_MORE:       take = st.more;
      nea_pkg::C_CHG:        take = st.chg;
      nea_pkg::C_CMD_EMPTY:  take = (st.cmd == nea_pkg::CMD_EMPTY);
      nea_pkg::C_NOT_LAST:   take = !st.last;
      nea_pkg::C_OUT_BUSY:   take = st.out_busy;
      nea_pkg::C_CLR_MORE:   take = st.clr_more;
      default:               take = 1'b0;
    endcase
    upc_nxt  = take ? word.target : nea_pkg::upc_t'(upc_r + 1'b1);
    ctl.op   = word.op;
    ctl.idle = (upc_r == nea_pkg::U_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= nea_pkg::U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/nfa_epsilon_acceptor_top.sv =====
// Top level of the epsilon-NFA acceptor: registers, table memories and set datapath.
// Depends on nea_pkg and nea_seq.
//
// After reset the block sweeps both tables to zero, one entry a cycle, and
// holds in_stall high meanwhile (config writes still land). A table write
// is decoded and then written in its own step. A string symbol scans the
// transition table one state per cycle on its single read port, then runs
// epsilon-closure passes over the epsilon table the same way until a pass
// adds nothing; the last symbol of a string then goes on to the report. The
// first symbol of a string also pays for the start closure. An empty-string
// request runs only the start closure before its report. The result sits in
// an output register, so the next item is taken while it waits. The epsilon
// closure is taken after every symbol.
module nfa_epsilon_acceptor_top #(
  parameter int NUM_STATES  = 16,
  parameter int NUM_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [3:0]  in_from_state,
  input  logic [3:0]  in_symbol,
  input  logic [15:0] in_target_set,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [15:0] out_final_set,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NS    = NUM_STATES;
  localparam int SW    = $clog2(NS);
  localparam int CW    = $clog2(NS + 1);
  localparam int DEPTH = NS * NUM_SYMBOLS;
  localparam int TAW   = $clog2(DEPTH);

  nea_pkg::ctl_t    ctl;
  nea_pkg::status_t st;

  // configuration
  logic [3:0]  start_r, start_nxt;
  logic [15:0] accept_r, accept_nxt;
  logic [4:0]  stay_r, stay_nxt;

  // latched item
  nea_pkg::cmd_t cmd_r, cmd_nxt;
  logic [3:0]    from_r, from_nxt;
  logic [3:0]    sym_r, sym_nxt;
  logic [15:0]   tgt_r, tgt_nxt;
  logic          last_r, last_nxt;

  // set datapath
  logic [NS-1:0]  cur_r, cur_nxt;
  logic [NS-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]  si_r, si_nxt;
  logic           chg_r, chg_nxt;
  logic           in_str_r, in_str_nxt;
  logic [TAW-1:0] clr_r, clr_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic        out_acc_r, out_acc_nxt;
  logic [15:0] out_set_r, out_set_nxt;

  // memories
  logic [NS-1:0] trans_mem [DEPTH];
  logic [NS-1:0] eps_mem [NS];
  logic [NS-1:0] trans_rd_r;
  logic [NS-1:0] eps_rd_r;

  logic           tr_we, tr_re, eps_we, eps_re;
  logic [TAW-1:0] tr_waddr, tr_raddr;
  logic [NS-1:0]  tr_wdata, eps_wdata;
  logic [SW-1:0]  eps_waddr;

  logic           sym_ok, from_ok, issue, more, cons, cons_on, out_free, stay_hit;
  logic [SW-1:0]  cons_idx;
  logic [NS-1:0]  tgt_fit, start_set;
  logic [NS+15:0] tgt_ext, cur_ext;
  logic [15:0]    cur16;

  always_comb begin
    sym_ok    = (int'(sym_r) < NUM_SYMBOLS);
    from_ok   = (int'(from_r) < NS);
    more      = (si_r != CW'(NS));
    issue     = more;
    cons      = (si_r != '0);
    cons_idx  = SW'(si_r - CW'(1));
    cons_on   = cons && cur_r[cons_idx];
    out_free  = !out_valid_r || !out_stall;
    stay_hit  = ({1'b0, sym_r} == stay_r);
    tgt_ext   = (NS + 16)'(tgt_r);
    tgt_fit   = tgt_ext[NS-1:0];
    cur_ext   = (NS + 16)'(cur_r);
    cur16     = cur_ext[15:0];
    start_set = (int'(start_r) < NS) ? (NS'(1) << start_r) : '0;
  end

  // memory port control
  always_comb begin
    tr_raddr = TAW'(si_r) * TAW'(NUM_SYMBOLS) + TAW'(sym_r);
    tr_re    = (ctl.op == nea_pkg::OP_TRANS) && issue && sym_ok;
    eps_re   = (ctl.op == nea_pkg::OP_CLOSE) && issue;
    if (ctl.op == nea_pkg::OP_CLEAR) begin
      tr_we     = 1'b1;
      tr_waddr  = clr_r;
      tr_wdata  = '0;
      eps_we    = (clr_r < TAW'(NS));
      eps_waddr = SW'(clr_r);
      eps_wdata = '0;
    end else begin
      tr_we     = (ctl.op == nea_pkg::OP_WR_TRANS) && from_ok && sym_ok;
      tr_waddr  = TAW'(from_r) * TAW'(NUM_SYMBOLS) + TAW'(sym_r);
      tr_wdata  = tgt_fit;
      eps_we    = (ctl.op == nea_pkg::OP_WR_EPS) && from_ok;
      eps_waddr = SW'(from_r);
      eps_wdata = tgt_fit;
    end
  end

  always_ff @(posedge clk) begin
    if (tr_we) begin
      trans_mem[tr_waddr] <= tr_wdata;
    end
    if (tr_re) begin
      trans_rd_r <= trans_mem[tr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (eps_we) begin
      eps_mem[eps_waddr] <= eps_wdata;
    end
    if (eps_re) begin
      eps_rd_r <= eps_mem[SW'(si_r)];
    end
  end

  // datapath next state
  always_comb begin
    start_nxt     = start_r;
    accept_nxt    = accept_r;
    stay_nxt      = stay_r;
    cmd_nxt       = cmd_r;
    from_nxt      = from_r;
    sym_nxt       = sym_r;
    tgt_nxt       = tgt_r;
    last_nxt      = last_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    si_nxt        = si_r;
    chg_nxt       = chg_r;
    in_str_nxt    = in_str_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_set_nxt   = out_set_r;

    unique case (ctl.op)
      nea_pkg::OP_CLEAR: begin
        clr_nxt = TAW'(clr_r + 1'b1);
      end
      nea_pkg::OP_ACCEPT: begin
        if (in_valid) begin
          cmd_nxt  = in_cmd;
          from_nxt = in_from_state;
          sym_nxt  = in_symbol;
          tgt_nxt  = in_target_set;
          last_nxt = in_last;
        end
      end
      nea_pkg::OP_LOAD_START: begin
        cur_nxt = start_set;
      end
      nea_pkg::OP_PASS_INIT: begin
        si_nxt  = '0;
        chg_nxt = 1'b0;
      end
      nea_pkg::OP_CLOSE: begin
        // in-place sweep: later states see bits added earlier in this pass
        si_nxt = more ? CW'(si_r + 1'b1) : si_r;
        if (cons_on) begin
          cur_nxt = cur_r | eps_rd_r;
          chg_nxt = chg_r | (|(eps_rd_r & ~cur_r));
        end
      end
      nea_pkg::OP_SET_STR: begin
        in_str_nxt = 1'b1;
      end
      nea_pkg::OP_TRANS_INIT: begin
        acc_nxt = stay_hit ? cur_r : '0;
        si_nxt  = '0;
      end
      nea_pkg::OP_TRANS: begin
        si_nxt = more ? CW'(si_r + 1'b1) : si_r;
        if (cons_on && sym_ok) begin
          acc_nxt = acc_r | trans_rd_r;
        end
      end
      nea_pkg::OP_MOVE: begin
        cur_nxt = acc_r;
      end
      nea_pkg::OP_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = |(cur16 & accept_r);
          out_set_nxt   = cur16;
          in_str_nxt    = 1'b0;
        end
      end
      nea_pkg::OP_NOP,
      nea_pkg::OP_WR_TRANS,
      nea_pkg::OP_WR_EPS: begin
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        nea_pkg::CFG_START_STATE: start_nxt  = cfg_wdata[3:0];
        nea_pkg::CFG_ACCEPT_MASK: accept_nxt = cfg_wdata;
        nea_pkg::CFG_STAY_SYMBOL: stay_nxt   = cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      accept_r    <= '0;
      stay_r      <= nea_pkg::STAY_NONE;
      cur_r       <= '0;
      si_r        <= '0;
      chg_r       <= 1'b0;
      in_str_r    <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      start_r     <= start_nxt;
      accept_r    <= accept_nxt;
      stay_r      <= stay_nxt;
      cur_r       <= cur_nxt;
      si_r        <= si_nxt;
      chg_r       <= chg_nxt;
      in_str_r    <= in_str_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    from_r    <= from_nxt;
    sym_r     <= sym_nxt;
    tgt_r     <= tgt_nxt;
    last_r    <= last_nxt;
    acc_r     <= acc_nxt;
    out_acc_r <= out_acc_nxt;
    out_set_r <= out_set_nxt;
  end

  always_comb begin
    st.item     = in_valid;
    st.cmd      = cmd_r;
    st.in_str   = in_str_r;
    st.more     = more;
    st.chg      = chg_r;
    st.last     = last_r;
    st.out_busy = !out_free;
    st.clr_more = (clr_r != TAW'(DEPTH - 1));
  end

  nea_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  assign in_stall      = !ctl.idle;
  assign out_valid     = out_valid_r;
  assign out_accepted  = out_acc_r;
  assign out_final_set = out_set_r;

  // a result appears only from the report step
  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.op == nea_pkg::OP_REPORT))
    else $error("result raised outside report step");

  // scan index stays within one pass
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    si_r <= CW'(NS))
    else $error("scan index past last state");

  // a delivered report closes the string
  a_report_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == nea_pkg::OP_REPORT && out_free) |=> !in_str_r)
    else $error("string still open after report");

  // no item taken during the table clear sweep
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == nea_pkg::OP_CLEAR) |-> in_stall)
    else $error("item accepted during clear sweep");

endmodule
